// File: rtl/core/pup_pkg.sv
// pup_pkg: shared types, codes and constants of the picture unit register port
// used by pup_regs, pup_sprite_ram and picture_unit_register_port_unit
// no dependencies
`timescale 1ns / 1ps

package pup_pkg;

    // sprite attribute memory
    localparam int SPRITE_BYTES_DEF = 256;

    // field widths
    localparam int OP_W    = 2;
    localparam int REG_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int REQ_W   = 2;
    localparam int VADDR_W = 16;

    // access kinds
    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_STATUS = 2'd2;

    // register numbers
    localparam logic [REG_W-1:0] REG_CONTROL  = 3'd0;
    localparam logic [REG_W-1:0] REG_MASK     = 3'd1;
    localparam logic [REG_W-1:0] REG_STATUS   = 3'd2;
    localparam logic [REG_W-1:0] REG_SPR_ADDR = 3'd3;
    localparam logic [REG_W-1:0] REG_SPR_DATA = 3'd4;
    localparam logic [REG_W-1:0] REG_SCROLL   = 3'd5;
    localparam logic [REG_W-1:0] REG_VADDR    = 3'd6;
    localparam logic [REG_W-1:0] REG_VDATA    = 3'd7;

    // video memory request codes
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

    // bit positions
    localparam int VBLANK_BIT  = 7;
    localparam int STEP32_BIT  = 2;

    // pointer steps
    localparam logic [VADDR_W-1:0] VSTEP_ONE = 16'd1;
    localparam logic [VADDR_W-1:0] VSTEP_ROW = 16'd32;

    // result of one access, before the sprite read data is merged in
    typedef struct packed {
        logic [BYTE_W-1:0]  read_data;
        logic               access_error;
        logic [REQ_W-1:0]   vram_request;
        logic [VADDR_W-1:0] vram_address;
        logic [BYTE_W-1:0]  vram_write_data;
        logic [BYTE_W-1:0]  control_value;
        logic [BYTE_W-1:0]  mask_value;
        logic [BYTE_W-1:0]  scroll_first;
        logic [BYTE_W-1:0]  scroll_second;
        logic               sprite_read;
    } pup_result_t;

    // sprite memory access of one item
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] wr_data;
    } pup_spr_access_t;

endpackage

// File: rtl/core/pup_sprite_ram.sv
// pup_sprite_ram: sprite attribute memory, one write or one read per cycle while en is high
// depends on pup_pkg
`timescale 1ns / 1ps

module pup_sprite_ram
    import pup_pkg::*;
#(
    parameter int SPRITE_BYTES = SPRITE_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              en,
    input  pup_spr_access_t   acc,
    output logic [BYTE_W-1:0] rd_data_reg
);

    localparam int AW = $clog2(SPRITE_BYTES);

    logic [BYTE_W-1:0] mem [SPRITE_BYTES];

    // write and read share the clock edge; an item does only one of them
    always_ff @(posedge clk)
    begin
        if (en && acc.wr_en)
        begin
            mem[acc.addr[AW-1:0]] <= acc.wr_data;
        end
        if (en && acc.rd_en)
        begin
            rd_data_reg <= mem[acc.addr[AW-1:0]];
        end
    end

endmodule

// File: rtl/core/pup_regs.sv
// pup_regs: register file and access decode of the picture unit register port
// depends on pup_pkg
`timescale 1ns / 1ps

module pup_regs
    import pup_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [OP_W-1:0]    operation,
    input  logic [REG_W-1:0]   register_index,
    input  logic [BYTE_W-1:0]  write_data,
    input  logic [BYTE_W-1:0]  vram_data_in,
    output pup_result_t        result,
    output pup_spr_access_t    spr_acc
);

    logic [BYTE_W-1:0]  control_reg, control_next;
    logic [BYTE_W-1:0]  mask_reg, mask_next;
    logic [BYTE_W-1:0]  status_reg, status_next;
    logic [BYTE_W-1:0]  spr_ptr_reg, spr_ptr_next;
    logic               toggle_reg, toggle_next;
    logic [BYTE_W-1:0]  scroll0_reg, scroll0_next;
    logic [BYTE_W-1:0]  scroll1_reg, scroll1_next;
    logic [VADDR_W-1:0] vptr_reg, vptr_next;
    logic [VADDR_W-1:0] vstep;

    assign vstep = control_reg[STEP32_BIT] ? VSTEP_ROW : VSTEP_ONE;

    always_comb
    begin
        control_next = control_reg;
        mask_next    = mask_reg;
        status_next  = status_reg;
        spr_ptr_next = spr_ptr_reg;
        toggle_next  = toggle_reg;
        scroll0_next = scroll0_reg;
        scroll1_next = scroll1_reg;
        vptr_next    = vptr_reg;

        result.read_data       = '0;
        result.access_error    = 1'b0;
        result.vram_request    = REQ_NONE;
        result.vram_address    = '0;
        result.vram_write_data = '0;
        result.sprite_read     = 1'b0;

        spr_acc.wr_en   = 1'b0;
        spr_acc.rd_en   = 1'b0;
        spr_acc.addr    = spr_ptr_reg;
        spr_acc.wr_data = write_data;

        case (operation)
            OP_READ:
            begin
                case (register_index)
                    REG_STATUS:
                    begin
                        result.read_data        = status_reg;
                        status_next[VBLANK_BIT] = 1'b0;
                    end
                    REG_SPR_DATA:
                    begin
                        result.sprite_read = 1'b1;
                        spr_acc.rd_en      = 1'b1;
                        spr_ptr_next       = spr_ptr_reg + 8'd1;
                    end
                    REG_VDATA:
                    begin
                        result.read_data    = vram_data_in;
                        result.vram_request = REQ_READ;
                        result.vram_address = vptr_reg;
                        vptr_next           = vptr_reg + vstep;
                    end
                    default:
                    begin
                        result.access_error = 1'b1;
                    end
                endcase
            end
            OP_WRITE:
            begin
                case (register_index)
                    REG_CONTROL:  control_next = write_data;
                    REG_MASK:     mask_next    = write_data;
                    REG_STATUS:   result.access_error = 1'b1;
                    REG_SPR_ADDR: spr_ptr_next = write_data;
                    REG_SPR_DATA:
                    begin
                        spr_acc.wr_en = 1'b1;
                        spr_ptr_next  = spr_ptr_reg + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (toggle_reg)
                        begin
                            scroll1_next = write_data;
                        end
                        else
                        begin
                            scroll0_next = write_data;
                        end
                        toggle_next = ~toggle_reg;
                    end
                    REG_VADDR:
                    begin
                        // high byte first, then low byte
                        if (toggle_reg)
                        begin
                            vptr_next = {vptr_reg[VADDR_W-1:BYTE_W], write_data};
                        end
                        else
                        begin
                            vptr_next = {write_data, vptr_reg[BYTE_W-1:0]};
                        end
                        toggle_next = ~toggle_reg;
                    end
                    default:
                    begin
                        result.vram_request    = REQ_WRITE;
                        result.vram_address    = vptr_reg;
                        result.vram_write_data = write_data;
                        vptr_next              = vptr_reg + vstep;
                    end
                endcase
            end
            OP_STATUS:
            begin
                status_next = write_data;
            end
            default:
            begin
                // unused access kind: no effect
            end
        endcase

        result.control_value = control_next;
        result.mask_value    = mask_next;
        result.scroll_first  = scroll0_next;
        result.scroll_second = scroll1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg <= '0;
            mask_reg    <= '0;
            status_reg  <= '0;
            spr_ptr_reg <= '0;
            toggle_reg  <= 1'b0;
            scroll0_reg <= '0;
            scroll1_reg <= '0;
            vptr_reg    <= '0;
        end
        else if (en)
        begin
            control_reg <= control_next;
            mask_reg    <= mask_next;
            status_reg  <= status_next;
            spr_ptr_reg <= spr_ptr_next;
            toggle_reg  <= toggle_next;
            scroll0_reg <= scroll0_next;
            scroll1_reg <= scroll1_next;
            vptr_reg    <= vptr_next;
        end
    end

endmodule

// File: rtl/core/picture_unit_register_port_unit.sv
// picture_unit_register_port_unit: top level of the picture unit register port
// depends on pup_pkg, pup_regs and pup_sprite_ram
`timescale 1ns / 1ps
//
//  channel   direction  tuser                                 tdata
//  s_axis    in         [1:0] operation, [4:2] register_index  [7:0] write_data,
//                                                              [15:8] vram_data_in
//  m_axis    out        [0] access_error, [2:1] vram_request   [7:0] read_data,
//                                                              [23:8] vram_address,
//                                                              [31:24] vram_write_data,
//                                                              [39:32] control_value,
//                                                              [47:40] mask_value,
//                                                              [55:48] scroll_first,
//                                                              [63:56] scroll_second
//
//  one item a cycle sustained while m_axis is not stalled; an item accepted on s_axis
//  passes through the input register, then the result register, before it shows on m_axis
//  the register file and sprite memory read/write are done in the cycle an item
//  moves from the input register to the result register, so items never overlap
//  on state
//  the sprite memory read data is registered alongside the result and merged at the port
//  reset clears the valid flags and the register file; sprite memory is not cleared
//  a stalled m_axis holds the result; s_axis keeps taking items while the input
//  register is empty or moving on

module picture_unit_register_port_unit
    import pup_pkg::*;
#(
    parameter int SPRITE_BYTES = SPRITE_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // write_data, vram_data_in
    input  logic [4:0]  s_axis_tuser,   // operation, register_index

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // read_data, vram_address, vram_write_data,
                                        // control_value, mask_value, scroll_first,
                                        // scroll_second
    output logic [2:0]  m_axis_tuser    // access_error, vram_request
);

    // input register
    logic               in_valid_reg;
    logic [OP_W-1:0]    in_op_reg;
    logic [REG_W-1:0]   in_idx_reg;
    logic [BYTE_W-1:0]  in_wdata_reg;
    logic [BYTE_W-1:0]  in_vdata_reg;

    // result register
    logic               out_valid_reg;
    pup_result_t        out_reg;

    logic               advance;
    logic               take;
    pup_result_t        result;
    pup_spr_access_t    spr_acc;
    logic [BYTE_W-1:0]  spr_rd_data;
    logic [BYTE_W-1:0]  read_byte;

    // item moves into the result register when that register is free or drains
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers need no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_op_reg    <= s_axis_tuser[OP_W-1:0];
            in_idx_reg   <= s_axis_tuser[OP_W+REG_W-1:OP_W];
            in_wdata_reg <= s_axis_tdata[BYTE_W-1:0];
            in_vdata_reg <= s_axis_tdata[2*BYTE_W-1:BYTE_W];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    // register file and access decode
    pup_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (advance),
        .operation      (in_op_reg),
        .register_index (in_idx_reg),
        .write_data     (in_wdata_reg),
        .vram_data_in   (in_vdata_reg),
        .result         (result),
        .spr_acc        (spr_acc)
    );

    // sprite memory, read data lands together with the result register
    pup_sprite_ram #(
        .SPRITE_BYTES (SPRITE_BYTES)
    ) u_sprite_ram (
        .clk         (clk),
        .en          (advance),
        .acc         (spr_acc),
        .rd_data_reg (spr_rd_data)
    );

    assign read_byte = out_reg.sprite_read ? spr_rd_data : out_reg.read_data;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.scroll_second, out_reg.scroll_first,
                            out_reg.mask_value, out_reg.control_value,
                            out_reg.vram_write_data, out_reg.vram_address,
                            read_byte};
    assign m_axis_tuser  = {out_reg.vram_request, out_reg.access_error};

endmodule
